FILE: rtl/core/cmta_pkg.sv
// ============================================================================
// cmta_pkg: shared types and constants of the cube map texel address unit
// Widths, face codes, register indexes and the records passed between the
// classifier front end, the queue and the divider back end.
// ============================================================================
package cmta_pkg;

    localparam int DIR_WIDTH     = 16;
    localparam int MAX_FACE_SIZE = 1024;

    localparam int CFG_W   = 11;
    localparam int SIZE_W  = $clog2(MAX_FACE_SIZE + 1);
    localparam int MAG_W   = DIR_WIDTH;
    localparam int NUM_W   = MAG_W + 1;
    localparam int PROD_W  = SIZE_W + NUM_W;
    localparam int QUO_W   = SIZE_W;
    localparam int COORD_W = 12;
    localparam int FACE_W  = 3;

    localparam int S_TDATA_W = ((3 * DIR_WIDTH + 7) / 8) * 8;
    localparam int M_FIELD_W = FACE_W + 2 * COORD_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] FACE_SIZE_RESET = CFG_W'(256);

    // register index, taken from paddr above the byte offset
    localparam logic [0:0] REG_FACE_SIZE = 1'b0;

    typedef enum logic [FACE_W-1:0] {
        FACE_PX = 3'd0,
        FACE_MX = 3'd1,
        FACE_PY = 3'd2,
        FACE_MY = 3'd3,
        FACE_PZ = 3'd4,
        FACE_MZ = 3'd5
    } face_t;

    // classified direction, ready for the divider
    typedef struct packed {
        face_t              face;
        logic               zero;
        logic [SIZE_W-1:0]  size;
        logic [NUM_W-1:0]   num_u;
        logic [NUM_W-1:0]   num_v;
        logic [NUM_W-1:0]   den;
        logic [COORD_W-1:0] col_off;
        logic [COORD_W-1:0] row_off;
    } cls_item_t;

    // one divider pipeline stage
    typedef struct packed {
        face_t              face;
        logic               zero;
        logic [SIZE_W-1:0]  size;
        logic [NUM_W-1:0]   den;
        logic [PROD_W-1:0]  rem_u;
        logic [PROD_W-1:0]  rem_v;
        logic [QUO_W-1:0]   q_u;
        logic [QUO_W-1:0]   q_v;
        logic [COORD_W-1:0] col_off;
        logic [COORD_W-1:0] row_off;
    } div_item_t;

endpackage

FILE: rtl/core/cmta_front.sv
// ============================================================================
// cmta_front: direction classifier
// Swizzle the direction, pick the major axis and face, and form the
// numerators, denominator, effective size and cross offsets.
// ============================================================================
module cmta_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cmta_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [cmta_pkg::CFG_W-1:0]     face_size,
    output logic                           push_valid,
    input  logic                           push_ready,
    output cmta_pkg::cls_item_t            push_data
);
    import cmta_pkg::*;

    function automatic logic [MAG_W-1:0] mag(input logic signed [DIR_WIDTH:0] v);
        logic signed [DIR_WIDTH:0] n;
        n = -v;
        return v[DIR_WIDTH] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    logic signed [DIR_WIDTH-1:0] dx, dy, dz;
    logic signed [DIR_WIDTH:0]   cx, cy, cz, uc, vc;
    logic [MAG_W-1:0]            ax, ay, az, major;
    logic [MAG_W+1:0]            sum_u, sum_v;
    logic [SIZE_W-1:0]           size;
    logic [COORD_W-1:0]          s1, s2, s3;
    face_t                       face;

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

    assign dx = s_tdata[DIR_WIDTH-1:0];
    assign dy = s_tdata[2*DIR_WIDTH-1:DIR_WIDTH];
    assign dz = s_tdata[3*DIR_WIDTH-1:2*DIR_WIDTH];

    // cube axes are (-x, z, y)
    assign cx = -{dx[DIR_WIDTH-1], dx};
    assign cy = {dz[DIR_WIDTH-1], dz};
    assign cz = {dy[DIR_WIDTH-1], dy};

    assign ax = mag(cx);
    assign ay = mag(cy);
    assign az = mag(cz);

    // later face wins ties
    always_comb begin
        priority if (az >= ax && az >= ay) begin
            major = az;
            if (cz > 0) begin
                face = FACE_PZ; uc = cx;  vc = cy;
            end else begin
                face = FACE_MZ; uc = -cx; vc = cy;
            end
        end else if (ay >= ax && ay >= az) begin
            major = ay;
            if (cy > 0) begin
                face = FACE_PY; uc = cx; vc = -cz;
            end else begin
                face = FACE_MY; uc = cx; vc = cz;
            end
        end else begin
            major = ax;
            if (cx > 0) begin
                face = FACE_PX; uc = -cz; vc = cy;
            end else begin
                face = FACE_MX; uc = cz;  vc = cy;
            end
        end
    end

    assign sum_u = {2'b00, major} + {uc[DIR_WIDTH], uc};
    assign sum_v = {2'b00, major} - {vc[DIR_WIDTH], vc};

    // hold the size inside its legal range
    always_comb begin
        priority if (face_size == '0) begin
            size = SIZE_W'(1);
        end else if (32'(face_size) > 32'(MAX_FACE_SIZE)) begin
            size = SIZE_W'(MAX_FACE_SIZE);
        end else begin
            size = SIZE_W'(face_size);
        end
    end

    assign s1 = COORD_W'(size);
    assign s2 = COORD_W'({size, 1'b0});
    assign s3 = s2 + s1;

    always_comb begin
        push_data.face  = face;
        push_data.zero  = (major == '0);
        push_data.size  = size;
        push_data.num_u = sum_u[NUM_W-1:0];
        push_data.num_v = sum_v[NUM_W-1:0];
        push_data.den   = {major, 1'b0};
        unique case (face)
            FACE_PX: begin push_data.col_off = s2; push_data.row_off = s1; end
            FACE_MX: begin push_data.col_off = '0; push_data.row_off = s1; end
            FACE_PY: begin push_data.col_off = s1; push_data.row_off = '0; end
            FACE_MY: begin push_data.col_off = s1; push_data.row_off = s2; end
            FACE_PZ: begin push_data.col_off = s1; push_data.row_off = s1; end
            default: begin push_data.col_off = s3; push_data.row_off = s1; end
        endcase
    end

endmodule

FILE: rtl/core/cmta_queue.sv
// ============================================================================
// cmta_queue: short queue between classifier and divider
// Small register FIFO; lets the front keep accepting while the back stalls.
// ============================================================================
module cmta_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  cmta_pkg::cls_item_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output cmta_pkg::cls_item_t pop_data
);
    import cmta_pkg::*;

    cls_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/cmta_back.sv
// ============================================================================
// cmta_back: scaling and division pipeline
// Multiply by the face size, divide one quotient bit per stage, clamp,
// add the cross offset and hold the result in the output register.
// ============================================================================
module cmta_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  cmta_pkg::cls_item_t            pop_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cmta_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]                     m_tuser
);
    import cmta_pkg::*;

    div_item_t          stg_reg  [QUO_W+1];
    div_item_t          stg_next [QUO_W+1];
    logic [QUO_W:0]     vld_reg;
    logic               adv;
    logic               out_valid_reg;
    logic [M_FIELD_W-1:0] out_data_reg, out_data_next;
    logic               out_zero_reg, out_zero_next;
    logic [QUO_W-1:0]   lu, lv;
    logic [SIZE_W-1:0]  size_m1;

    assign adv       = !out_valid_reg || m_tready;
    assign pop_ready = adv;

    always_comb begin
        logic [PROD_W-1:0] trial;
        stg_next[0].face    = pop_data.face;
        stg_next[0].zero    = pop_data.zero;
        stg_next[0].size    = pop_data.size;
        stg_next[0].den     = pop_data.den;
        stg_next[0].rem_u   = PROD_W'(pop_data.size) * PROD_W'(pop_data.num_u);
        stg_next[0].rem_v   = PROD_W'(pop_data.size) * PROD_W'(pop_data.num_v);
        stg_next[0].q_u     = '0;
        stg_next[0].q_v     = '0;
        stg_next[0].col_off = pop_data.col_off;
        stg_next[0].row_off = pop_data.row_off;
        // restoring division, most significant quotient bit first
        for (int k = 0; k < QUO_W; k++) begin
            stg_next[k+1] = stg_reg[k];
            trial = PROD_W'(stg_reg[k].den) << (QUO_W - 1 - k);
            if (stg_reg[k].rem_u >= trial) begin
                stg_next[k+1].rem_u             = stg_reg[k].rem_u - trial;
                stg_next[k+1].q_u[QUO_W-1-k]    = 1'b1;
            end
            if (stg_reg[k].rem_v >= trial) begin
                stg_next[k+1].rem_v             = stg_reg[k].rem_v - trial;
                stg_next[k+1].q_v[QUO_W-1-k]    = 1'b1;
            end
        end
    end

    // clamp to size-1, face centre for a zero direction
    assign size_m1 = stg_reg[QUO_W].size - 1'b1;

    always_comb begin
        if (stg_reg[QUO_W].zero) begin
            lu = stg_reg[QUO_W].size >> 1;
            lv = stg_reg[QUO_W].size >> 1;
        end else begin
            lu = (stg_reg[QUO_W].q_u > size_m1) ? size_m1 : stg_reg[QUO_W].q_u;
            lv = (stg_reg[QUO_W].q_v > size_m1) ? size_m1 : stg_reg[QUO_W].q_v;
        end
        out_data_next = {stg_reg[QUO_W].row_off + COORD_W'(lv),
                         stg_reg[QUO_W].col_off + COORD_W'(lu),
                         stg_reg[QUO_W].face};
        out_zero_next = stg_reg[QUO_W].zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg       <= {vld_reg[QUO_W-1:0], pop_valid};
            out_valid_reg <= vld_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stg_reg      <= stg_next;
            out_data_reg <= out_data_next;
            out_zero_reg <= out_zero_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - M_FIELD_W)'(0), out_data_reg};
    assign m_tuser  = out_zero_reg;

endmodule

FILE: rtl/core/cube_map_texel_address_unit.sv
// ============================================================================
// cube_map_texel_address_unit: horizontal-cross cube map texel address
// Path: queue slot, divider stages (one quotient bit a stage), output register.
// Throughput: one direction per cycle, set by the divider, unless m_tready stalls.
// A four-entry queue decouples the classifier from the divider pipeline.
// Reset: face_size returns to 256, queue and pipeline empty, no clearing pass.
// ============================================================================
module cube_map_texel_address_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cmta_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cmta_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cmta_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // direction input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: dir_x [15:0], dir_y [31:16], dir_z [47:32]
    input  logic [cmta_pkg::S_TDATA_W-1:0]   s_tdata,
    // texel result
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: face [2:0], texel_col [14:3], texel_row [26:15], zeros above
    output logic [cmta_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: zero_dir [0]
    output logic [0:0]                       m_tuser
);
    import cmta_pkg::*;

    logic [CFG_W-1:0] face_size_reg, face_size_next;
    logic             cfg_wr;
    logic             sel_face_size;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    cls_item_t        push_data, pop_data;

    // ------------------------------------------------------------------
    // Configuration: register index sits above the two byte-offset bits.
    // A write lands on the access cycle; pready never stalls.
    // ------------------------------------------------------------------
    assign pready        = 1'b1;
    assign sel_face_size = (paddr[APB_ADDR_W-1:2] == REG_FACE_SIZE);
    assign cfg_wr        = psel && penable && pwrite && pready;

    always_comb begin
        face_size_next = face_size_reg;
        if (cfg_wr && sel_face_size) begin
            face_size_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_size_reg <= FACE_SIZE_RESET;
        end else begin
            face_size_reg <= face_size_next;
        end
    end

    // unused addresses read as zero
    assign prdata = sel_face_size ? APB_DATA_W'(face_size_reg) : '0;

    // ------------------------------------------------------------------
    // Front: classify each direction as it transfers in. The size is
    // captured with the item, so the back never looks at the register.
    // ------------------------------------------------------------------
    cmta_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .face_size  (face_size_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Queue: absorb items while the result side stalls.
    cmta_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: scale, divide, clamp, offset; the whole pipe advances together
    // whenever the output register is free or being drained.
    cmta_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/core/cmta_checker.sv
// ============================================================================
// cmta_checker: port-level checks of the cube map texel address unit
// Watches the stream ports for output holding, reset state and flag coding.
// ============================================================================
module cmta_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cmta_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);
    import cmta_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // reset empties the queue, so the input side is free again
    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    // a zero direction always lands on the -Z face
    a_zero_face: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[FACE_W-1:0] == FACE_MZ)
        else $error("zero direction not on -Z face");

endmodule

bind cube_map_texel_address_unit cmta_checker u_cmta_checker (.*);
